@@ hdl/gvn_pkg.sv @@
// Package for the gradient vector normalizer.
// Holds configuration register indexes, widths and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gvn_pkg;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam int THRESHOLD_BITS = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_THREE_D_MODE = 2'd1;

  localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 16'd1;
  localparam logic                      THREE_D_RESET   = 1'b1;
endpackage
`default_nettype wire

@@ hdl/gvn_if.sv @@
// Stream interfaces of the gradient vector normalizer.
// Input gradients and output unit vectors; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface gvn_in_if #(parameter int GRADIENT_BITS = 16);
  logic                            valid;
  logic                            ready;
  logic signed [GRADIENT_BITS-1:0] grad_x;
  logic signed [GRADIENT_BITS-1:0] grad_y;
  logic signed [GRADIENT_BITS-1:0] grad_z;
  modport source (output valid, output grad_x, output grad_y, output grad_z, input ready);
  modport sink   (input valid, input grad_x, input grad_y, input grad_z, output ready);
endinterface

interface gvn_out_if #(parameter int OUT_BITS = 16);
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] unit_x;
  logic signed [OUT_BITS-1:0] unit_y;
  logic signed [OUT_BITS-1:0] unit_z;
  modport source (output valid, output unit_x, output unit_y, output unit_z, input ready);
  modport sink   (input valid, input unit_x, input unit_y, input unit_z, output ready);
endinterface
`default_nettype wire

@@ hdl/gvn_lane.sv @@
// One normalizer lane: pipelined bit-per-stage search for |g|*2^F/sqrt(S).
// Keeps q^2*S and q*S incrementally, so no multiplier is needed.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module gvn_lane #(
  parameter int SW = 32,   // width of S
  parameter int PW = 62,   // width of products and target
  parameter int F  = 14    // fraction bits of the result
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [SW-1:0] sum_sq,
  input  wire logic [PW-1:0] target,
  output logic      [F:0]    mag
);
  localparam int NS = F + 1;

  logic [PW-1:0] p_r  [1:NS];
  logic [PW-1:0] qs_r [1:NS];
  logic [PW-1:0] s_r  [1:NS];
  logic [PW-1:0] t_r  [1:NS];
  logic [F:0]    q_r  [1:NS];

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_stage
      localparam int B = F - k;
      logic [PW-1:0] p_in, qs_in, s_in, t_in, cand;
      logic [F:0]    q_in;
      logic          take;
      if (k == 0) begin : g_first
        assign p_in  = '0;
        assign qs_in = '0;
        assign q_in  = '0;
        assign s_in  = PW'(sum_sq);
        assign t_in  = target;
      end else begin : g_next
        assign p_in  = p_r[k];
        assign qs_in = qs_r[k];
        assign q_in  = q_r[k];
        assign s_in  = s_r[k];
        assign t_in  = t_r[k];
      end
      // try setting bit B: (q+2^B)^2 S = q^2 S + 2^(B+1) qS + 2^(2B) S
      assign cand = p_in + (qs_in << (B + 1)) + (s_in << (2 * B));
      assign take = (cand <= t_in);
      always_ff @(posedge clk) begin
        if (en) begin
          p_r[k+1]  <= take ? cand : p_in;
          qs_r[k+1] <= take ? (qs_in + (s_in << B)) : qs_in;
          q_r[k+1]  <= take ? (q_in | ((F+1)'(1) << B)) : q_in;
          s_r[k+1]  <= s_in;
          t_r[k+1]  <= t_in;
        end
      end
    end
  endgenerate

  assign mag = q_r[NS];
endmodule
`default_nettype wire

@@ hdl/gradient_vector_normalizer.sv @@
// Top level of the gradient vector normalizer.
// Uses gvn_pkg, the gvn_in_if / gvn_out_if interfaces and three gvn_lane instances.
//
// Usage: gradients (grad_x, grad_y, grad_z, signed Q8.8) enter on in_ch, a
// valid/ready stream; each transfer yields one unit vector (signed Q1.F) on
// out_ch. Registers are written through cfg_we/cfg_index/cfg_data: index 0 is
// the threshold (unsigned Q8.8), index 1 the 3-D mode bit; write them idle.
// Throughput: one voxel per clock while the receiver does not stall. Stages:
// input, square, sum/compare, one stage per result bit (the bit-per-stage
// root search in each lane), output register.
// Reset sets threshold 1 and 3-D mode, and empties the pipeline.
// When the receiver stalls, the whole pipeline holds and in_ch.ready drops;
// while the pipeline holds bubbles it still holds, so new voxels wait.
`timescale 1ns / 1ps
`default_nettype none
module gradient_vector_normalizer
  import gvn_pkg::*;
#(
  parameter int GRADIENT_BITS        = 16,
  parameter int OUTPUT_FRACTION_BITS = 14
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  gvn_in_if.sink                         in_ch,
  gvn_out_if.source                      out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);
  localparam int G  = GRADIENT_BITS;
  localparam int F  = OUTPUT_FRACTION_BITS;
  localparam int SW = 2 * G;
  localparam int PW = 2 * G + 2 * F + 2;
  localparam int TW = (SW > 2 * THRESHOLD_BITS) ? SW : 2 * THRESHOLD_BITS;
  localparam int LAT = F + 1;
  localparam int OW = F + 2;

  // configuration
  logic [THRESHOLD_BITS-1:0]   threshold_r;
  logic                        three_d_r;
  logic [2*THRESHOLD_BITS-1:0] t2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RESET;
      three_d_r   <= THREE_D_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD:    threshold_r <= cfg_data[THRESHOLD_BITS-1:0];
        REG_THREE_D_MODE: three_d_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    t2_r <= threshold_r * threshold_r;
  end

  // global advance: hold everything while the output waits
  logic en;
  logic out_vld_r;
  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en && rst_n;

  // stage 1: magnitudes and signs
  logic signed [G-1:0] gz_sel;
  logic [G-1:0] ax_r, ay_r, az_r;
  logic [2:0]   sg1_r;
  assign gz_sel = three_d_r ? in_ch.grad_z : '0;

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r  <= in_ch.grad_x[G-1] ? G'(-in_ch.grad_x) : G'(in_ch.grad_x);
      ay_r  <= in_ch.grad_y[G-1] ? G'(-in_ch.grad_y) : G'(in_ch.grad_y);
      az_r  <= gz_sel[G-1] ? G'(-gz_sel) : G'(gz_sel);
      sg1_r <= {gz_sel[G-1], in_ch.grad_y[G-1], in_ch.grad_x[G-1]};
    end
  end

  // stage 2: squares
  logic [SW-1:0] sx_r, sy_r, sz_r;
  logic [2:0]    sg2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sx_r  <= ax_r * ax_r;
      sy_r  <= ay_r * ay_r;
      sz_r  <= az_r * az_r;
      sg2_r <= sg1_r;
    end
  end

  // stage 3: sum, threshold compare, targets
  logic [SW+1:0] sum_w;
  logic [SW-1:0] s_r;
  logic [PW-1:0] tx_r, ty_r, tz_r;
  logic          below_r;
  logic [2:0]    sg3_r;
  assign sum_w = (SW+2)'(sx_r) + (SW+2)'(sy_r) + (SW+2)'(sz_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s_r     <= sum_w[SW-1:0];
      below_r <= (sum_w[SW-1:0] == '0) || (TW'(sum_w[SW-1:0]) < TW'(t2_r));
      tx_r    <= PW'(sx_r) << (2 * F);
      ty_r    <= PW'(sy_r) << (2 * F);
      tz_r    <= PW'(sz_r) << (2 * F);
      sg3_r   <= sg2_r;
    end
  end

  // lanes
  logic [F:0] qx, qy, qz;
  gvn_lane #(.SW(SW), .PW(PW), .F(F)) u_lane_x (
    .clk(clk), .en(en), .sum_sq(s_r), .target(tx_r), .mag(qx));
  gvn_lane #(.SW(SW), .PW(PW), .F(F)) u_lane_y (
    .clk(clk), .en(en), .sum_sq(s_r), .target(ty_r), .mag(qy));
  gvn_lane #(.SW(SW), .PW(PW), .F(F)) u_lane_z (
    .clk(clk), .en(en), .sum_sq(s_r), .target(tz_r), .mag(qz));

  // sideband alongside the lanes
  logic [3:0] side_r [1:LAT];
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[1] <= {below_r, sg3_r};
      for (int i = 2; i <= LAT; i++) side_r[i] <= side_r[i-1];
    end
  end

  // valid chain
  logic [LAT+2:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[LAT+1:0], in_ch.valid};
      out_vld_r <= vld_r[LAT+2];
    end
  end

  // merge: apply signs and the threshold
  logic signed [OW-1:0] ux_r, uy_r, uz_r;
  function automatic logic signed [OW-1:0] apply_sign(input logic [F:0] q, input logic neg,
                                                      input logic zero);
    logic signed [OW-1:0] v;
    v = $signed({1'b0, q});
    if (zero) return '0;
    return neg ? -v : v;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      ux_r <= apply_sign(qx, side_r[LAT][0], side_r[LAT][3]);
      uy_r <= apply_sign(qy, side_r[LAT][1], side_r[LAT][3]);
      uz_r <= apply_sign(qz, side_r[LAT][2], side_r[LAT][3]);
    end
  end

  assign out_ch.valid  = out_vld_r;
  assign out_ch.unit_x = ux_r;
  assign out_ch.unit_y = uy_r;
  assign out_ch.unit_z = uz_r;
endmodule
`default_nettype wire

@@ dv/gradient_vector_normalizer_test.sv @@
// Testbench for the gradient vector normalizer: random and directed gradients,
// exact integer prediction of thresholded unit vectors, in-order checking.
// Depends on gvn_pkg, gvn_in_if / gvn_out_if and the gradient_vector_normalizer RTL.
`timescale 1ns / 1ps
`default_nettype none

class unit_vector_board;
  logic [15:0] threshold;
  bit          three_d;
  logic signed [15:0] exp_x[$], exp_y[$], exp_z[$];
  int errors;

  function new();
    threshold = gvn_pkg::THRESHOLD_RESET;
    three_d   = gvn_pkg::THREE_D_RESET;
    errors    = 0;
  endfunction

  // largest q with q*q*s <= g*g*2^28, then the sign of g
  function logic signed [15:0] scale_comp(logic signed [15:0] g, longint unsigned s);
    longint unsigned ag;
    logic [127:0] target, prod;
    longint unsigned q, c;
    ag = (g < 0) ? -longint'(g) : longint'(g);
    target = (128'(ag * ag)) << 28;
    q = 0;
    for (int b = 14; b >= 0; b--) begin
      c = q | (64'd1 << b);
      prod = 128'(c * c) * 128'(s);
      if (prod <= target) q = c;
    end
    return (g < 0) ? -16'(q) : 16'(q);
  endfunction

  // note one accepted gradient
  function void note_gradient(logic signed [15:0] gx, gy, gz);
    longint unsigned s, t2;
    logic signed [15:0] z;
    z = three_d ? gz : 16'sd0;
    s = longint'(gx) * longint'(gx) + longint'(gy) * longint'(gy) + longint'(z) * longint'(z);
    t2 = longint'(threshold) * longint'(threshold);
    if (s == 0 || s < t2) begin
      exp_x.push_back(0); exp_y.push_back(0); exp_z.push_back(0);
    end else begin
      exp_x.push_back(scale_comp(gx, s));
      exp_y.push_back(scale_comp(gy, s));
      exp_z.push_back(three_d ? scale_comp(gz, s) : 16'sd0);
    end
  endfunction

  // compare one result transfer with the oldest expectation
  function void check_unit(logic signed [15:0] ux, uy, uz);
    logic signed [15:0] ex, ey, ez;
    if (exp_x.size() == 0) begin
      $display("%0t: unexpected result %0d %0d %0d", $time, ux, uy, uz);
      errors++;
      return;
    end
    ex = exp_x.pop_front(); ey = exp_y.pop_front(); ez = exp_z.pop_front();
    if (ux !== ex) begin
      $display("%0t: unit_x expected %0d actual %0d", $time, ex, ux); errors++;
    end
    if (uy !== ey) begin
      $display("%0t: unit_y expected %0d actual %0d", $time, ey, uy); errors++;
    end
    if (uz !== ez) begin
      $display("%0t: unit_z expected %0d actual %0d", $time, ez, uz); errors++;
    end
  endfunction
endclass

module gradient_vector_normalizer_test;
  import gvn_pkg::*;

  localparam int LATENCY = 14 + 5;
  localparam int WATCHDOG = 5000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  int idle_cycles;
  bit sending_done;
  bit out_stall_free;

  gvn_in_if  #(.GRADIENT_BITS(16)) in_ch();
  gvn_out_if #(.OUT_BITS(16))      out_ch();

  unit_vector_board board = new();

  gradient_vector_normalizer #(.GRADIENT_BITS(16), .OUTPUT_FRACTION_BITS(14)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // record transfers and count idle cycles at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        board.note_gradient(in_ch.grad_x, in_ch.grad_y, in_ch.grad_z);
      if (out_ch.valid && out_ch.ready)
        board.check_unit(out_ch.unit_x, out_ch.unit_y, out_ch.unit_z);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // stall the receiver at random, with stall-free stretches
  initial begin
    int wait_n;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
      wait_n = out_stall_free ? 0 : $urandom_range(0, 18);
      if (wait_n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
    end
  end

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_THRESHOLD) board.threshold = val;
    else if (idx == REG_THREE_D_MODE) board.three_d = val[0];
  endtask

  // present one gradient and hold it until the transfer
  task automatic send_gradient(logic [15:0] gx, gy, gz, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.grad_x <= gx; in_ch.grad_y <= gy; in_ch.grad_z <= gz;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.exp_x.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_comp();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // stimulus: directed corners, then random phases over register settings
  initial begin
    logic [15:0] th_set[6];
    th_set = '{16'd0, 16'd1, 16'd300, 16'd4096, 16'hffff, 16'd40};
    rst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_ch.valid = 1'b0; in_ch.grad_x = '0; in_ch.grad_y = '0; in_ch.grad_z = '0;
    idle_cycles = 0; sending_done = 0; out_stall_free = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: zero, extremes, single components, tiny, threshold edge
    send_gradient(16'h0000, 16'h0000, 16'h0000, 1);
    send_gradient(16'h8000, 16'h8000, 16'h8000, 1);
    send_gradient(16'h7fff, 16'h7fff, 16'h7fff, 0);
    send_gradient(16'h8000, 16'h0000, 16'h0000, 0);
    send_gradient(16'h0000, 16'h7fff, 16'h0000, 0);
    send_gradient(16'h0000, 16'h0000, 16'hffff, 0);
    send_gradient(16'h0001, 16'h0000, 16'h0000, 0);
    send_gradient(16'h7fff, 16'h8000, 16'h0001, 0);
    send_gradient(16'h0003, 16'hfffc, 16'h000c, 0);
    drain();
    write_reg(REG_THRESHOLD, 16'd0);
    send_gradient(16'h0000, 16'h0000, 16'h0000, 0);
    send_gradient(16'h0000, 16'h0000, 16'h0001, 0);
    drain();
    write_reg(REG_THRESHOLD, 16'd5);
    send_gradient(16'h0003, 16'h0004, 16'h0000, 0);
    send_gradient(16'h0003, 16'h0003, 16'h0000, 0);
    send_gradient(16'hfffd, 16'hfffc, 16'h0000, 0);
    drain();
    write_reg(REG_THREE_D_MODE, 16'hfffe);
    send_gradient(16'h0000, 16'h0000, 16'h7fff, 0);
    send_gradient(16'h0003, 16'h0004, 16'h8000, 0);
    send_gradient(16'h8000, 16'h7fff, 16'h1234, 0);
    drain();

    // random phases
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(REG_THRESHOLD, (ph < 6) ? th_set[ph] : 16'($urandom_range(0, 2000)));
      write_reg(REG_THREE_D_MODE, 16'($urandom));
      out_stall_free = (ph % 4 == 3);
      for (int k = 0; k < 104; k++)
        send_gradient(pick_comp(), pick_comp(), pick_comp(), out_stall_free || ($urandom_range(0, 3) == 0));
      drain();
    end
    sending_done = 1;
  end

  // finish on completion or when nothing moves for too long
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (sending_done) begin
        if (board.errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
      end else if (idle_cycles >= WATCHDOG) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end
endmodule
`default_nettype wire

@@ filelist.f @@
hdl/gvn_pkg.sv
hdl/gvn_if.sv
hdl/gvn_lane.sv
hdl/gradient_vector_normalizer.sv
dv/gradient_vector_normalizer_test.sv
